[hdl/slws_pkg.sv]
// shared types, constants and the colour table of the status led encoder
package slws_pkg;

    localparam int MaxNodesDefault = 8;
    localparam int TickW           = 15;
    localparam int CountW          = 4;
    localparam int StateW          = 2;
    localparam int CfgIdxW         = 3;
    localparam int FrameBits       = 24;
    localparam int SymCntW         = 5;
    localparam int PrevW           = 3;

    localparam logic [CfgIdxW-1:0] REG_NODES_EXPECTED = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ZERO_LOW       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ONE_HIGH       = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ONE_LOW        = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LATCH          = 3'd5;

    localparam logic [StateW-1:0] LED_BOOT    = 2'd0;
    localparam logic [StateW-1:0] LED_NONE    = 2'd1;
    localparam logic [StateW-1:0] LED_PARTIAL = 2'd2;
    localparam logic [StateW-1:0] LED_ALL     = 2'd3;

    localparam logic [PrevW-1:0] PREV_NONE = 3'd4;

    typedef struct packed {
        logic                 start;
        logic [StateW-1:0]    led_state;
        logic [FrameBits-1:0] colour;
    } frame_cmd_t;

    typedef struct packed {
        logic [TickW-1:0] zero_high;
        logic [TickW-1:0] zero_low;
        logic [TickW-1:0] one_high;
        logic [TickW-1:0] one_low;
        logic [TickW-1:0] latch;
    } tick_cfg_t;

    // green, red, blue
    function automatic logic [FrameBits-1:0] colour_grb(input logic [StateW-1:0] st);
        logic [FrameBits-1:0] c;
        case (st)
            LED_BOOT:    c = {8'd0, 8'd0, 8'd16};
            LED_NONE:    c = {8'd0, 8'd20, 8'd0};
            LED_PARTIAL: c = {8'd8, 8'd18, 8'd0};
            LED_ALL:     c = {8'd18, 8'd0, 8'd0};
            default:     c = '0;
        endcase
        return c;
    endfunction

endpackage

[hdl/slws_req_if.sv]
// request channel: poll ticks and clear requests
interface slws_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic                        master_ready;
    logic [slws_pkg::CountW-1:0] nodes_up;

    modport source (output valid, req_type, master_ready, nodes_up, input ready);
    modport sink   (input valid, req_type, master_ready, nodes_up, output ready);
endinterface

[hdl/slws_sym_if.sv]
// symbol channel: pulse symbols toward the line driver
interface slws_sym_if;
    logic                        valid;
    logic                        ready;
    logic                        first_level;
    logic [slws_pkg::TickW-1:0]  first_ticks;
    logic                        second_level;
    logic [slws_pkg::TickW-1:0]  second_ticks;
    logic [slws_pkg::StateW-1:0] led_state;
    logic                        last_symbol;

    modport source (output valid, first_level, first_ticks, second_level, second_ticks,
                    led_state, last_symbol, input ready);
    modport sink   (input valid, first_level, first_ticks, second_level, second_ticks,
                    led_state, last_symbol, output ready);
endinterface

[hdl/slws_classify.sv]
// link state classification, change detection and frame command
module slws_classify #(
    parameter int MAX_NODES = slws_pkg::MaxNodesDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic                        req_type,
    input  logic                        master_ready,
    input  logic [slws_pkg::CountW-1:0] nodes_up,
    input  logic [slws_pkg::CountW-1:0] nodes_expected,
    output slws_pkg::frame_cmd_t        cmd
);
    import slws_pkg::*;

    localparam int CountMax = (1 << CountW) - 1;
    localparam int CapInt   = (MAX_NODES > CountMax) ? CountMax : MAX_NODES;
    localparam logic [CountW-1:0] LimitCap = CountW'(CapInt);

    logic [PrevW-1:0]  prev_reg;
    logic [PrevW-1:0]  prev_next;
    logic [CountW-1:0] limit;
    logic [StateW-1:0] st;

    always_comb
    begin
        limit = (nodes_expected > LimitCap) ? LimitCap : nodes_expected;
        if (!master_ready)
            st = LED_BOOT;
        else if (nodes_up == '0)
            st = LED_NONE;
        else if (nodes_up < limit)
            st = LED_PARTIAL;
        else
            st = LED_ALL;
    end

    always_comb
    begin
        cmd.start     = take && (req_type || ({1'b0, st} != prev_reg));
        cmd.led_state = req_type ? LED_BOOT : st;
        cmd.colour    = req_type ? '0 : colour_grb(st);
        prev_next     = (take && !req_type) ? {1'b0, st} : prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_reg <= PREV_NONE;
        else
            prev_reg <= prev_next;
    end

endmodule

[hdl/slws_serializer.sv]
// bit-serial frame shifter producing one pulse symbol per frame bit
module slws_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slws_pkg::frame_cmd_t cmd,
    input  slws_pkg::tick_cfg_t  ticks,
    output logic                 idle,
    slws_sym_if.source           sym
);
    import slws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } fsm_t;

    fsm_t                 fsm_reg, fsm_next;
    logic [FrameBits-1:0] shift_reg, shift_next;
    logic [SymCntW-1:0]   cnt_reg, cnt_next;
    logic [StateW-1:0]    state_reg, state_next;
    logic                 is_last;
    logic                 bit_now;

    assign idle    = (fsm_reg == S_IDLE);
    assign is_last = (cnt_reg == SymCntW'(FrameBits));
    assign bit_now = shift_reg[FrameBits-1];

    always_comb
    begin
        sym.valid        = (fsm_reg == S_SEND);
        sym.first_level  = !is_last;
        sym.first_ticks  = is_last ? ticks.latch : (bit_now ? ticks.one_high : ticks.zero_high);
        sym.second_level = 1'b0;
        sym.second_ticks = is_last ? '0 : (bit_now ? ticks.one_low : ticks.zero_low);
        sym.led_state    = state_reg;
        sym.last_symbol  = is_last;
    end

    always_comb
    begin
        fsm_next   = fsm_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        state_next = state_reg;
        case (fsm_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    fsm_next   = S_SEND;
                    shift_next = cmd.colour;
                    state_next = cmd.led_state;
                    cnt_next   = '0;
                end
            end
            S_SEND:
            begin
                if (sym.ready)
                begin
                    if (is_last)
                        fsm_next = S_IDLE;
                    else
                    begin
                        shift_next = {shift_reg[FrameBits-2:0], 1'b0};
                        cnt_next   = cnt_reg + 1'b1;
                    end
                end
            end
            default:
                fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        state_reg <= state_next;
    end

endmodule

[hdl/status_led_ws2812_symbol_encoder.sv]
// top level of the status led ws2812 symbol encoder
// Each accepted word is a poll or a clear request. A poll whose link state matches the
// last one kept produces nothing and the block stays ready. A poll with a new state,
// and every clear request, produces one frame of 25 symbols: 24 GRB data bits MSB first
// and a closing latch symbol flagged last_symbol. The frame leaves one bit per cycle
// from a 24-bit shift register while the sink holds ready high; the next word is taken
// the cycle after the last symbol goes out. Tick registers must be written only while
// no frame is in flight.
module status_led_ws2812_symbol_encoder #(
    parameter int MAX_NODES = slws_pkg::MaxNodesDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [slws_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [slws_pkg::TickW-1:0]   cfg_data,
    slws_req_if.sink                     req_ch,
    slws_sym_if.source                   sym_ch
);
    import slws_pkg::*;

    logic [CountW-1:0] nodes_expected_reg;
    tick_cfg_t         ticks_reg;
    frame_cmd_t        cmd;
    logic              idle;
    logic              take;

    assign req_ch.ready = idle;
    assign take         = req_ch.valid && idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_expected_reg  <= 4'd8;
            ticks_reg.zero_high <= 15'd3;
            ticks_reg.zero_low  <= 15'd9;
            ticks_reg.one_high  <= 15'd6;
            ticks_reg.one_low   <= 15'd6;
            ticks_reg.latch     <= 15'd900;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NODES_EXPECTED: nodes_expected_reg  <= cfg_data[CountW-1:0];
                REG_ZERO_HIGH:      ticks_reg.zero_high <= cfg_data;
                REG_ZERO_LOW:       ticks_reg.zero_low  <= cfg_data;
                REG_ONE_HIGH:       ticks_reg.one_high  <= cfg_data;
                REG_ONE_LOW:        ticks_reg.one_low   <= cfg_data;
                REG_LATCH:          ticks_reg.latch     <= cfg_data;
                default:            ;
            endcase
        end
    end

    slws_classify #(
        .MAX_NODES (MAX_NODES)
    ) u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .req_type       (req_ch.req_type),
        .master_ready   (req_ch.master_ready),
        .nodes_up       (req_ch.nodes_up),
        .nodes_expected (nodes_expected_reg),
        .cmd            (cmd)
    );

    slws_serializer u_serializer (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ticks (ticks_reg),
        .idle  (idle),
        .sym   (sym_ch)
    );

    // no word taken while a frame is going out
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |-> !sym_ch.valid)
        else $error("word accepted during frame");

    // frame ends after the latch symbol is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (sym_ch.valid && sym_ch.ready && sym_ch.last_symbol) |=> !sym_ch.valid)
        else $error("frame continues past latch symbol");

    // latch symbol is low with no second part
    assert property (@(posedge clk) disable iff (!rst_n)
        (sym_ch.valid && sym_ch.last_symbol) |->
            (!sym_ch.first_level && sym_ch.second_ticks == '0))
        else $error("malformed latch symbol");

    // a frame starts only from a taken word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!sym_ch.valid ##1 sym_ch.valid) |-> $past(take))
        else $error("frame without request");

endmodule
